[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used across the fade interpolator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PFI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PFI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pfi_pkg.sv]
// ----------------------------------------------------------------------------
// pfi_pkg
// Types, register codes and helper functions of the palette fade interpolator.
// ----------------------------------------------------------------------------
package pfi_pkg;

  localparam int COMP_W     = 8;
  localparam int FADE_W     = 6;
  localparam int NUM_COMP   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  // Quotient bits resolved per divider stage, and stages needed for a full byte
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = COMP_W / DIV_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADE_MODE   = 3'd0,
    REG_FIRST_ENTRY = 3'd1,
    REG_LAST_ENTRY  = 3'd2,
    REG_FADE_STEPS  = 3'd3,
    REG_FADE_RED    = 3'd4,
    REG_FADE_GREEN  = 3'd5,
    REG_FADE_BLUE   = 3'd6
  } pfi_reg_t;

  typedef struct packed {
    logic                                mode;
    logic [COMP_W-1:0]                   first;
    logic [COMP_W-1:0]                   last;
    logic [COMP_W-1:0]                   steps;
    logic [NUM_COMP-1:0][FADE_W-1:0]     fade;
  } pfi_cfg_t;

  typedef struct packed {
    logic [COMP_W-1:0]                   idx;
    logic [COMP_W-1:0]                   step;
    logic [NUM_COMP-1:0][COMP_W-1:0]     cur;
    logic [NUM_COMP-1:0][COMP_W-1:0]     goal;
  } pfi_in_t;

  // One colour component on its way through multiplier and divider.
  // rem/low hold the running dividend; low fills up with quotient bits.
  typedef struct packed {
    logic [COMP_W-1:0] cur;
    logic [COMP_W-1:0] goal;
    logic              up;
    logic [COMP_W-1:0] rem;
    logic [COMP_W-1:0] low;
  } pfi_lane_t;

  typedef struct packed {
    logic [COMP_W-1:0]         idx;
    logic [COMP_W-1:0]         step;
    logic                      fin;
    logic                      in_range;
    pfi_lane_t [NUM_COMP-1:0]  lane;
  } pfi_item_t;

  // c*255/63 = 4c + floor(c/21) for c in 0..63
  function automatic logic [COMP_W-1:0] expand6(input logic [FADE_W-1:0] c);
    logic [1:0] q;
    begin
      if (c >= 6'd63) begin
        q = 2'd3;
      end else if (c >= 6'd42) begin
        q = 2'd2;
      end else if (c >= 6'd21) begin
        q = 2'd1;
      end else begin
        q = 2'd0;
      end
      expand6 = {c, 2'b00} + {6'd0, q};
    end
  endfunction

endpackage

[design/pfi_if.sv]
// ----------------------------------------------------------------------------
// pfi_in_if / pfi_out_if
// Valid/ready channels carrying palette entries in and faded entries out.
// ----------------------------------------------------------------------------
interface pfi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] entry_index;
  logic [7:0] step_index;
  logic [7:0] cur_red;
  logic [7:0] cur_green;
  logic [7:0] cur_blue;
  logic [7:0] goal_red;
  logic [7:0] goal_green;
  logic [7:0] goal_blue;

  modport source (
    output valid, entry_index, step_index, cur_red, cur_green, cur_blue,
           goal_red, goal_green, goal_blue,
    input  ready
  );
  modport sink (
    input  valid, entry_index, step_index, cur_red, cur_green, cur_blue,
           goal_red, goal_green, goal_blue,
    output ready
  );
endinterface

interface pfi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (
    output valid, out_index, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, out_index, out_red, out_green, out_blue,
    output ready
  );
endinterface

[design/pfi_prep.sv]
// ----------------------------------------------------------------------------
// pfi_prep
// Front two stages: goal select, range test and difference, then the multiply.
// ----------------------------------------------------------------------------
module pfi_prep import pfi_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_valid,
  input  pfi_in_t   in_item,
  input  pfi_cfg_t  cfg,
  output logic      v_out,
  output pfi_item_t item_out
);

  logic      v1_r;
  logic      v2_r;
  pfi_item_t s1_r;
  pfi_item_t s1_nxt;
  pfi_item_t s2_r;
  pfi_item_t s2_nxt;

  // Stage 1: pick the goal and form |goal - cur| per component
  always_comb begin
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] c;
    s1_nxt          = '0;
    s1_nxt.idx      = in_item.idx;
    s1_nxt.step     = in_item.step;
    s1_nxt.fin      = (in_item.step >= cfg.steps);
    s1_nxt.in_range = (in_item.idx >= cfg.first) && (in_item.idx <= cfg.last) &&
                      (int'(in_item.idx) < PALETTE_ENTRIES);
    for (int k = 0; k < NUM_COMP; k++) begin
      c = in_item.cur[k];
      g = cfg.mode ? in_item.goal[k] : expand6(cfg.fade[k]);
      s1_nxt.lane[k].cur  = c;
      s1_nxt.lane[k].goal = g;
      s1_nxt.lane[k].up   = (g >= c);
      s1_nxt.lane[k].low  = (g >= c) ? (g - c) : (c - g);
      s1_nxt.lane[k].rem  = '0;
    end
  end

  // Stage 2: difference times step, split into the divider's rem/low halves
  always_comb begin
    logic [2*COMP_W-1:0] prod;
    s2_nxt = s1_r;
    for (int k = 0; k < NUM_COMP; k++) begin
      prod = {{COMP_W{1'b0}}, s1_r.lane[k].low} * {{COMP_W{1'b0}}, s1_r.step};
      s2_nxt.lane[k].rem = prod[2*COMP_W-1:COMP_W];
      s2_nxt.lane[k].low = prod[COMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign v_out    = v2_r;
  assign item_out = s2_r;

endmodule

[design/pfi_div_stage.sv]
// ----------------------------------------------------------------------------
// pfi_div_stage
// One stage of the restoring divider: resolves DIV_BITS quotient bits per lane.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfi_div_stage import pfi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [COMP_W-1:0] steps,
  input  logic              v_in,
  input  pfi_item_t         item_in,
  output logic              v_out,
  output pfi_item_t         item_out
);

  logic      v_r;
  pfi_item_t item_r;
  pfi_item_t item_nxt;

  // Per lane and per quotient bit: shift one dividend bit into the remainder, subtract the divisor if it fits
  always_comb begin
    logic [COMP_W-1:0] rem;
    logic [COMP_W-1:0] low;
    logic [COMP_W:0]   t;
    logic              q;
    item_nxt = item_in;
    for (int k = 0; k < NUM_COMP; k++) begin
      rem = item_in.lane[k].rem;
      low = item_in.lane[k].low;
      for (int b = 0; b < DIV_BITS; b++) begin
        t = {rem, low[COMP_W-1]};
        if (t >= {1'b0, steps}) begin
          rem = COMP_W'(t - {1'b0, steps});
          q   = 1'b1;
        end else begin
          rem = t[COMP_W-1:0];
          q   = 1'b0;
        end
        low = {low[COMP_W-2:0], q};
      end
      item_nxt.lane[k].rem = rem;
      item_nxt.lane[k].low = low;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign v_out    = v_r;
  assign item_out = item_r;

  // On intermediate frames the partial remainder stays below the divisor
  `PFI_ASSERT_IMPL(a_rem_below_steps, clk, rst_n, v_r && !item_r.fin, (item_r.lane[0].rem < steps) && (item_r.lane[1].rem < steps) && (item_r.lane[2].rem < steps), "divider remainder not below fade_steps")
  `PFI_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !adv, $stable(v_r), "divider stage valid changed during stall")

endmodule

[design/palette_fade_interpolator.sv]
// ----------------------------------------------------------------------------
// palette_fade_interpolator
// Computes one faded palette entry per input item.
// ----------------------------------------------------------------------------
// Usage: palette entries arrive on in_ch (index, frame number, current colour
// and, for fade-in, goal colour); the faded entry leaves on out_ch with its
// index. Both channels are valid/ready; an item moves when both are high.
// Registers are written through cfg_we/cfg_index/cfg_data, one per cycle;
// the user must write them only while no item is in flight (not enforced).
// Pipeline registers from acceptance to out_ch.valid, in order:
// goal/difference stage, multiply stage, four divider stages of two quotient
// bits each, and the output register.
// Throughput: one item per cycle while the receiver does not stall out_ch.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register
// defaults: fade out to black over 30 frames across all entries.
// When the receiver holds out_ch.ready low with a result waiting, the whole
// pipeline freezes and in_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_fade_interpolator import pfi_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  pfi_in_if.sink                 in_ch,
  pfi_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  pfi_cfg_t  cfg_r;
  pfi_cfg_t  cfg_nxt;
  logic      adv;
  pfi_in_t   in_item;
  logic      d_v    [DIV_STAGES+1];
  pfi_item_t d_item [DIV_STAGES+1];

  logic                            out_valid_r;
  logic [COMP_W-1:0]               out_idx_r;
  logic [NUM_COMP-1:0][COMP_W-1:0] out_rgb_r;
  logic [NUM_COMP-1:0][COMP_W-1:0] out_rgb_nxt;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (pfi_reg_t'(cfg_index))
        REG_FADE_MODE:   cfg_nxt.mode    = cfg_data[0];
        REG_FIRST_ENTRY: cfg_nxt.first   = cfg_data[COMP_W-1:0];
        REG_LAST_ENTRY:  cfg_nxt.last    = cfg_data[COMP_W-1:0];
        REG_FADE_STEPS:  cfg_nxt.steps   = cfg_data[COMP_W-1:0];
        REG_FADE_RED:    cfg_nxt.fade[0] = cfg_data[FADE_W-1:0];
        REG_FADE_GREEN:  cfg_nxt.fade[1] = cfg_data[FADE_W-1:0];
        REG_FADE_BLUE:   cfg_nxt.fade[2] = cfg_data[FADE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= 1'b0;
      cfg_r.first <= 8'd0;
      cfg_r.last  <= 8'd255;
      cfg_r.steps <= 8'd30;
      cfg_r.fade  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Advance everything unless a finished result is held by the receiver
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    in_item.idx     = in_ch.entry_index;
    in_item.step    = in_ch.step_index;
    in_item.cur[0]  = in_ch.cur_red;
    in_item.cur[1]  = in_ch.cur_green;
    in_item.cur[2]  = in_ch.cur_blue;
    in_item.goal[0] = in_ch.goal_red;
    in_item.goal[1] = in_ch.goal_green;
    in_item.goal[2] = in_ch.goal_blue;
  end

  pfi_prep #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .v_out    (d_v[0]),
    .item_out (d_item[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    pfi_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .steps    (cfg_r.steps),
      .v_in     (d_v[s]),
      .item_in  (d_item[s]),
      .v_out    (d_v[s+1]),
      .item_out (d_item[s+1])
    );
  end

  // Final frame or later gives the goal; inside the range apply the signed step, else keep cur
  always_comb begin
    pfi_lane_t ln;
    for (int k = 0; k < NUM_COMP; k++) begin
      ln = d_item[DIV_STAGES].lane[k];
      if (d_item[DIV_STAGES].fin) begin
        out_rgb_nxt[k] = ln.goal;
      end else if (d_item[DIV_STAGES].in_range) begin
        out_rgb_nxt[k] = ln.up ? (ln.cur + ln.low) : (ln.cur - ln.low);
      end else begin
        out_rgb_nxt[k] = ln.cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_v[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_v[DIV_STAGES]) begin
      out_idx_r <= d_item[DIV_STAGES].idx;
      out_rgb_r <= out_rgb_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_index = out_idx_r;
  assign out_ch.out_red   = out_rgb_r[0];
  assign out_ch.out_green = out_rgb_r[1];
  assign out_ch.out_blue  = out_rgb_r[2];

  `PFI_ASSERT_IMPL(a_stall_blocks_input, clk, rst_n, out_valid_r && !out_ch.ready, !in_ch.ready, "input accepted while output stalled")

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams palette entries through the fade interpolator under several
// register settings and random handshake gaps, predicts each faded entry
// and checks every result against the oldest prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pfi_pkg::*;

  localparam int                   PALETTE_ENTRIES = 256;
  localparam int                   WATCHDOG_LIMIT  = 3000;
  localparam int                   LATENCY         = 7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 3'd7;

  typedef struct packed {
    logic [7:0]      idx;
    logic [7:0]      step;
    logic [2:0][7:0] cur;   // 0 red, 1 green, 2 blue
    logic [2:0][7:0] goal;
  } fade_entry_t;

  typedef struct packed {
    logic [7:0]      idx;
    logic [2:0][7:0] rgb;
  } faded_entry_t;

  class fade_scoreboard;
    logic            mode;
    logic [7:0]      first_entry;
    logic [7:0]      last_entry;
    logic [7:0]      steps;
    logic [2:0][5:0] fade_rgb;
    faded_entry_t    pending_colours[$];
    int              failures;

    function new();
      mode        = 1'b0;
      first_entry = 8'd0;
      last_entry  = 8'd255;
      steps       = 8'd30;
      fade_rgb    = '0;
      failures    = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        REG_FADE_MODE:   mode        = data[0];
        REG_FIRST_ENTRY: first_entry = data;
        REG_LAST_ENTRY:  last_entry  = data;
        REG_FADE_STEPS:  steps       = data;
        REG_FADE_RED:    fade_rgb[0] = data[5:0];
        REG_FADE_GREEN:  fade_rgb[1] = data[5:0];
        REG_FADE_BLUE:   fade_rgb[2] = data[5:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] widen_fade(logic [5:0] c);
      int v;
      v = (int'(c) * 255) / 63;
      return v[7:0];
    endfunction

    // Linear step from cur towards goal; magnitude truncates towards zero
    function logic [7:0] blend_component(logic [7:0] cur, logic [7:0] goal, logic [7:0] step);
      int mag;
      if (goal >= cur) begin
        mag = ((int'(goal) - int'(cur)) * int'(step)) / int'(steps);
        return cur + mag[7:0];
      end
      mag = ((int'(cur) - int'(goal)) * int'(step)) / int'(steps);
      return cur - mag[7:0];
    endfunction

    function faded_entry_t faded_colour(fade_entry_t e);
      faded_entry_t    res;
      logic [2:0][7:0] goal;
      logic            in_range;
      for (int k = 0; k < 3; k++) begin
        goal[k] = mode ? e.goal[k] : widen_fade(fade_rgb[k]);
      end
      in_range = e.idx >= first_entry && e.idx <= last_entry &&
                 int'(e.idx) < PALETTE_ENTRIES;
      res.idx = e.idx;
      for (int k = 0; k < 3; k++) begin
        if (e.step >= steps) begin
          res.rgb[k] = goal[k];
        end else if (in_range) begin
          res.rgb[k] = blend_component(e.cur[k], goal[k], e.step);
        end else begin
          res.rgb[k] = e.cur[k];
        end
      end
      return res;
    endfunction

    function void note_entry(fade_entry_t e);
      pending_colours.push_back(faded_colour(e));
    endfunction

    function void check_result(faded_entry_t got);
      faded_entry_t want;
      logic [7:0]   want_f[4];
      logic [7:0]   got_f[4];
      string        names[4];
      if (pending_colours.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result: index %0d rgb %0d %0d %0d", got.idx,
                   got.rgb[0], got.rgb[1], got.rgb[2]);
        end
        return;
      end
      want = pending_colours.pop_front();
      names = '{"out_index", "out_red", "out_green", "out_blue"};
      want_f[0] = want.idx;
      got_f[0]  = got.idx;
      for (int k = 0; k < 3; k++) begin
        want_f[k+1] = want.rgb[k];
        got_f[k+1]  = got.rgb[k];
      end
      for (int k = 0; k < 4; k++) begin
        if (got_f[k] !== want_f[k]) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch on %s (entry %0d): expected %0d, got %0d", names[k],
                     want.idx, want_f[k], got_f[k]);
          end
        end
      end
    endfunction

    function int outstanding();
      return pending_colours.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pfi_in_if  in_ch();
  pfi_out_if out_ch();

  palette_fade_interpolator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fade_scoreboard sb;
  bit             tx_gappy;
  bit             rx_stalls;
  int             rx_hold_len;
  int             idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] random_component();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic fade_entry_t make_entry(logic [7:0] idx, logic [7:0] step,
                                             logic [7:0] cr, logic [7:0] cg, logic [7:0] cb,
                                             logic [7:0] gr, logic [7:0] gg, logic [7:0] gb);
    fade_entry_t e;
    e.idx     = idx;
    e.step    = step;
    e.cur[0]  = cr;
    e.cur[1]  = cg;
    e.cur[2]  = cb;
    e.goal[0] = gr;
    e.goal[1] = gg;
    e.goal[2] = gb;
    return e;
  endfunction

  // Bias indexes towards the range edges and frames towards the fade
  function automatic fade_entry_t random_entry();
    fade_entry_t e;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       e.idx = sb.first_entry - 8'd1;
        1:       e.idx = sb.first_entry;
        2:       e.idx = sb.last_entry;
        default: e.idx = sb.last_entry + 8'd1;
      endcase
    end else begin
      e.idx = 8'($urandom_range(0, 255));
    end
    if (sb.steps != 0 && $urandom_range(0, 3) != 0) begin
      e.step = 8'($urandom_range(0, sb.steps));
    end else begin
      e.step = 8'($urandom_range(0, 255));
    end
    for (int k = 0; k < 3; k++) begin
      e.cur[k]  = random_component();
      e.goal[k] = random_component();
    end
    return e;
  endfunction

  task automatic send_entry(input fade_entry_t e);
    int gap;
    gap = tx_gappy ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.entry_index <= e.idx;
    in_ch.step_index  <= e.step;
    in_ch.cur_red     <= e.cur[0];
    in_ch.cur_green   <= e.cur[1];
    in_ch.cur_blue    <= e.cur[2];
    in_ch.goal_red    <= e.goal[0];
    in_ch.goal_green  <= e.goal[1];
    in_ch.goal_blue   <= e.goal[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_register(idx, data);
  endtask

  task automatic program_fade(input logic m, input logic [7:0] f, input logic [7:0] l,
                              input logic [7:0] s, input logic [5:0] r,
                              input logic [5:0] g, input logic [5:0] b);
    wait_drained();
    write_reg(REG_FADE_MODE, {7'd0, m});
    write_reg(REG_FIRST_ENTRY, f);
    write_reg(REG_LAST_ENTRY, l);
    write_reg(REG_FADE_STEPS, s);
    write_reg(REG_FADE_RED, {2'd0, r});
    write_reg(REG_FADE_GREEN, {2'd0, g});
    write_reg(REG_FADE_BLUE, {2'd0, b});
    // Writes past the register list must leave the settings alone
    write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
        out_ch.ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    fade_entry_t  e;
    faded_entry_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        e = make_entry(in_ch.entry_index, in_ch.step_index, in_ch.cur_red, in_ch.cur_green,
                       in_ch.cur_blue, in_ch.goal_red, in_ch.goal_green, in_ch.goal_blue);
        sb.note_entry(e);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.idx    = out_ch.out_index;
        got.rgb[0] = out_ch.out_red;
        got.rgb[1] = out_ch.out_green;
        got.rgb[2] = out_ch.out_blue;
        sb.check_result(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic       m;
    logic [7:0] f;
    logic [7:0] l;
    logic [7:0] s;
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;

    sb                = new();
    tx_gappy          = 1'b0;
    rx_stalls         = 1'b0;
    rx_hold_len       = 0;
    idle_cycles       = 0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_FADE_MODE;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.entry_index = '0;
    in_ch.step_index  = '0;
    in_ch.cur_red     = '0;
    in_ch.cur_green   = '0;
    in_ch.cur_blue    = '0;
    in_ch.goal_red    = '0;
    in_ch.goal_green  = '0;
    in_ch.goal_blue   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: fade out to black over 30 frames, all entries
    send_entry(make_entry(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_entry(make_entry(8'd255, 8'd29, 8'd255, 8'd0, 8'd128, 8'd0, 8'd0, 8'd0));
    send_entry(make_entry(8'd128, 8'd30, 8'd12, 8'd34, 8'd56, 8'd200, 8'd200, 8'd200));
    send_entry(make_entry(8'd7, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255));
    send_entry(make_entry(8'd64, 8'd15, 8'd255, 8'd1, 8'd254, 8'd1, 8'd2, 8'd3));

    // Fade in over 255 frames on entries 10..20
    program_fade(1'b1, 8'd10, 8'd20, 8'd255, 6'd63, 6'd63, 6'd63);
    send_entry(make_entry(8'd9, 8'd100, 8'd1, 8'd2, 8'd3, 8'd255, 8'd255, 8'd255));
    send_entry(make_entry(8'd10, 8'd254, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
    send_entry(make_entry(8'd20, 8'd254, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_entry(make_entry(8'd21, 8'd1, 8'd90, 8'd80, 8'd70, 8'd0, 8'd0, 8'd0));
    send_entry(make_entry(8'd15, 8'd255, 8'd90, 8'd80, 8'd70, 8'd170, 8'd85, 8'd5));
    send_entry(make_entry(8'd15, 8'd0, 8'd90, 8'd80, 8'd70, 8'd170, 8'd85, 8'd5));

    // Zero steps: every frame is the last one
    program_fade(1'b0, 8'd0, 8'd255, 8'd0, 6'd63, 6'd0, 6'd42);
    send_entry(make_entry(8'd0, 8'd0, 8'd10, 8'd20, 8'd30, 8'd1, 8'd1, 8'd1));
    send_entry(make_entry(8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_entry(make_entry(8'd100, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

    // Empty range: intermediate frames pass entries through
    program_fade(1'b1, 8'd200, 8'd100, 8'd8, 6'd21, 6'd20, 6'd22);
    send_entry(make_entry(8'd150, 8'd3, 8'd11, 8'd22, 8'd33, 8'd200, 8'd0, 8'd255));
    send_entry(make_entry(8'd200, 8'd7, 8'd11, 8'd22, 8'd33, 8'd200, 8'd0, 8'd255));
    send_entry(make_entry(8'd100, 8'd0, 8'd11, 8'd22, 8'd33, 8'd200, 8'd0, 8'd255));
    send_entry(make_entry(8'd50, 8'd8, 8'd11, 8'd22, 8'd33, 8'd200, 8'd0, 8'd255));

    // Single entry, one step, fade out with goal inputs at full scale
    program_fade(1'b0, 8'd255, 8'd255, 8'd1, 6'd21, 6'd20, 6'd22);
    send_entry(make_entry(8'd255, 8'd0, 8'd200, 8'd100, 8'd50, 8'd255, 8'd255, 8'd255));
    send_entry(make_entry(8'd254, 8'd0, 8'd200, 8'd100, 8'd50, 8'd255, 8'd255, 8'd255));
    send_entry(make_entry(8'd255, 8'd1, 8'd200, 8'd100, 8'd50, 8'd255, 8'd255, 8'd255));

    for (int p = 0; p < 8; p++) begin
      m = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       s = 8'd0;
        1:       s = 8'd1;
        2:       s = 8'd255;
        default: s = 8'($urandom_range(2, 64));
      endcase
      case ($urandom_range(0, 3))
        0: begin
          f = 8'd0;
          l = 8'd255;
        end
        1: begin
          f = 8'($urandom_range(0, 255));
          l = 8'($urandom_range(f, 255));
        end
        2: begin
          f = 8'($urandom_range(1, 255));
          l = 8'($urandom_range(0, f - 1));
        end
        default: begin
          f = 8'($urandom_range(0, 255));
          l = f;
        end
      endcase
      r = 6'($urandom_range(0, 63));
      g = 6'($urandom_range(0, 63));
      b = 6'($urandom_range(0, 63));
      program_fade(m, f, l, s, r, g, b);
      tx_gappy  = (p % 4) != 0;
      rx_stalls = (p % 3) != 1;
      for (int n = 0; n < 250; n++) begin
        // Hold the receiver off so the pipeline fills and stalls the input
        if (p == 2 && n == 40) rx_hold_len = 300;
        if (p == 3 && n == 150) wait_drained();
        send_entry(random_entry());
      end
    end

    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[palette_fade_interpolator.f]
+incdir+design
design/pfi_pkg.sv
design/pfi_if.sv
design/pfi_prep.sv
design/pfi_div_stage.sv
design/palette_fade_interpolator.sv
tb/sv/testbench.sv
